// ===== hdl/ltpd_pkg.sv =====
`timescale 1ns / 1ps
package ltpd_pkg;

   localparam logic [1:0] KIND_LINE_BYTE  = 2'd0;
   localparam logic [1:0] KIND_EVENT      = 2'd1;
   localparam logic [1:0] KIND_EMPTY_LINE = 2'd2;

   localparam logic [7:0] IMAGE_TYPE_RESET = 8'd1;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] byte_value;
      logic [7:0] event_id;
      logic       last_of_line;
      logic       length_error;
   } result_type;

endpackage

// ===== hdl/length_type_packet_deframer.sv =====
// Each input byte is registered in the byte register, and its result in the result register.
// Throughput: one byte per cycle; the byte register and the result register
// both advance together whenever the result register is free or being taken.
// Reset is synchronous and active high. It clears the parser state and both
// valid flags, and sets the image type code to 1.
`timescale 1ns / 1ps
module length_type_packet_deframer
   import ltpd_pkg::*;
#(
   parameter int HEADER_BYTES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_tvalid,
   output logic        csr_tready,
   input  logic [7:0]  csr_tdata,   // image_type_code
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // byte_value, event_id, length_error, zero fill
   output logic        rsp_tlast,
   output logic [1:0]  rsp_tuser    // kind
);

   localparam int IDX_W = $clog2(HEADER_BYTES);
   localparam logic [IDX_W-1:0] IDX_LEN_HI = IDX_W'(1);
   localparam logic [IDX_W-1:0] IDX_LEN_LO = IDX_W'(2);
   localparam logic [IDX_W-1:0] IDX_TYPE   = IDX_W'(4);
   localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(HEADER_BYTES - 1);
   localparam logic [15:0]      HDR_LEN    = 16'(HEADER_BYTES);

   logic [7:0]       image_type_ff;
   logic             byte_valid_ff, byte_valid_in;
   logic [7:0]       byte_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   result_type       rsp_ff, rsp_in;
   logic             has_result;

   logic             in_payload_ff, in_payload_in;
   logic [IDX_W-1:0] header_index_ff, header_index_in;
   logic [15:0]      packet_length_ff, packet_length_in;
   logic [7:0]       packet_type_ff, packet_type_in;
   logic [15:0]      payload_left_ff, payload_left_in;
   logic [7:0]       first_payload_ff, first_payload_in;

   logic             advance;
   logic             out_free;
   logic [7:0]       type_now;
   logic             is_first;
   logic             is_last;
   logic [7:0]       event_content;

   assign csr_tready = 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = byte_valid_ff && out_free;
   assign req_tready = !byte_valid_ff || advance;

   always_comb begin
      in_payload_in    = in_payload_ff;
      header_index_in  = header_index_ff;
      packet_length_in = packet_length_ff;
      packet_type_in   = packet_type_ff;
      payload_left_in  = payload_left_ff;
      first_payload_in = first_payload_ff;
      has_result       = 1'b0;
      rsp_in           = '0;
      type_now         = (header_index_ff == IDX_TYPE) ? byte_ff : packet_type_ff;
      is_first         = (payload_left_ff == (packet_length_ff - HDR_LEN));
      is_last          = (payload_left_ff <= 16'd1);
      event_content    = is_first ? byte_ff : first_payload_ff;

      if (!in_payload_ff) begin
         if (header_index_ff == IDX_LEN_HI) begin
            packet_length_in[15:8] = byte_ff;
         end
         if (header_index_ff == IDX_LEN_LO) begin
            packet_length_in[7:0] = byte_ff;
         end
         if (header_index_ff == IDX_TYPE) begin
            packet_type_in = byte_ff;
         end
         if (header_index_ff != IDX_LAST) begin
            header_index_in = header_index_ff + IDX_W'(1);
         end else begin
            header_index_in = '0;
            if (packet_length_ff <= HDR_LEN) begin
               has_result          = 1'b1;
               rsp_in.kind         = (type_now == image_type_ff) ? KIND_EMPTY_LINE
                                                                : KIND_EVENT;
               rsp_in.event_id     = type_now;
               rsp_in.length_error = 1'b1;
            end else begin
               payload_left_in  = packet_length_ff - HDR_LEN;
               first_payload_in = '0;
               in_payload_in    = 1'b1;
            end
         end
      end else begin
         if (is_first) begin
            first_payload_in = byte_ff;
         end
         payload_left_in = is_last ? 16'd0 : payload_left_ff - 16'd1;
         if (is_last) begin
            in_payload_in = 1'b0;
         end
         rsp_in.event_id = packet_type_ff;
         if (packet_type_ff == image_type_ff) begin
            has_result          = 1'b1;
            rsp_in.kind         = KIND_LINE_BYTE;
            rsp_in.byte_value   = byte_ff;
            rsp_in.last_of_line = is_last;
         end else if (is_last) begin
            has_result        = 1'b1;
            rsp_in.kind       = KIND_EVENT;
            rsp_in.byte_value = event_content;
         end
      end
   end

   always_comb begin
      byte_valid_in = byte_valid_ff;
      if (req_tvalid && req_tready) begin
         byte_valid_in = 1'b1;
      end else if (advance) begin
         byte_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = has_result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_type_ff    <= IMAGE_TYPE_RESET;
         byte_valid_ff    <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         in_payload_ff    <= 1'b0;
         header_index_ff  <= '0;
         packet_length_ff <= '0;
         packet_type_ff   <= '0;
         payload_left_ff  <= '0;
         first_payload_ff <= '0;
      end else begin
         byte_valid_ff <= byte_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_tvalid && csr_tready) begin
            image_type_ff <= csr_tdata;
         end
         if (advance) begin
            in_payload_ff    <= in_payload_in;
            header_index_ff  <= header_index_in;
            packet_length_ff <= packet_length_in;
            packet_type_ff   <= packet_type_in;
            payload_left_ff  <= payload_left_in;
            first_payload_ff <= first_payload_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         byte_ff <= req_tdata;
      end
      if (advance && has_result) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_ff.length_error, rsp_ff.event_id, rsp_ff.byte_value};
   assign rsp_tlast  = rsp_ff.last_of_line;
   assign rsp_tuser  = rsp_ff.kind;

endmodule

// ===== hdl/ltpd_checker.sv =====
`timescale 1ns / 1ps
module ltpd_checker
   import ltpd_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic [1:0]  rsp_tuser
);

   // A stalled result keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // Only a line byte can close a line.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser == KIND_LINE_BYTE)
      else $error("tlast on a result that is not a line byte");

   // A length error never carries a line byte, and its content is zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[16] |->
         (rsp_tuser == KIND_EVENT || rsp_tuser == KIND_EMPTY_LINE)
         && rsp_tdata[7:0] == 8'd0)
      else $error("bad result for a length error");

   // An empty line only comes from a length error.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_EMPTY_LINE |-> rsp_tdata[16] && !rsp_tlast)
      else $error("empty line without length error");

   // A result appearing on an idle output follows an input transfer through the byte register.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("result without a preceding input transfer");

endmodule

bind length_type_packet_deframer ltpd_checker u_ltpd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
   import ltpd_pkg::*;

   localparam int HEADER_LEN = 8;
   localparam int CYCLE_LIMIT = 1500000;
   localparam int DRAIN_CYCLES = 8;
   localparam int ITEM_COUNT = 800;

   class deframe_predictor;
      logic [7:0]  image_code;
      bit          in_payload;
      int unsigned header_pos;
      logic [15:0] pkt_length;
      logic [7:0]  pkt_type;
      logic [15:0] bytes_left;
      logic [7:0]  first_byte;
      result_type  expected_q[$];
      int unsigned mismatches;

      function new();
         image_code = IMAGE_TYPE_RESET;
         in_payload = 1'b0;
         header_pos = 0;
         pkt_length = '0;
         pkt_type = '0;
         bytes_left = '0;
         first_byte = '0;
         mismatches = 0;
      endfunction

      function void push_result(logic [1:0] kind, logic [7:0] value, logic last, logic err);
         result_type r;
         r.kind = kind;
         r.byte_value = value;
         r.event_id = pkt_type;
         r.last_of_line = last;
         r.length_error = err;
         expected_q.push_back(r);
      endfunction

      function void take_byte(logic [7:0] b);
         logic [15:0] total;
         bit          is_first;
         bit          is_last;
         if (!in_payload) begin
            case (header_pos)
               1: pkt_length[15:8] = b;
               2: pkt_length[7:0] = b;
               4: pkt_type = b;
               default: ;
            endcase
            if (header_pos + 1 < HEADER_LEN) begin
               header_pos++;
               return;
            end
            header_pos = 0;
            if (pkt_length <= 16'(HEADER_LEN)) begin
               push_result((pkt_type == image_code) ? KIND_EMPTY_LINE : KIND_EVENT,
                           8'h00, 1'b0, 1'b1);
               return;
            end
            bytes_left = pkt_length - 16'(HEADER_LEN);
            first_byte = '0;
            in_payload = 1'b1;
            return;
         end
         total = pkt_length - 16'(HEADER_LEN);
         is_first = (bytes_left == total);
         is_last = (bytes_left <= 16'd1);
         if (is_first) first_byte = b;
         bytes_left = is_last ? 16'd0 : bytes_left - 16'd1;
         if (is_last) in_payload = 1'b0;
         if (pkt_type == image_code)
            push_result(KIND_LINE_BYTE, b, is_last, 1'b0);
         else if (is_last)
            push_result(KIND_EVENT, first_byte, 1'b0, 1'b0);
      endfunction

      function void report(string msg);
         mismatches++;
         if (mismatches <= 10) $display("%0t: %s", $time, msg);
      endfunction

      function void check_result(result_type got, logic [6:0] fill);
         result_type want;
         if (expected_q.size() == 0) begin
            report($sformatf("unexpected result kind=%0d value=%02h id=%02h last=%0b err=%0b",
                             got.kind, got.byte_value, got.event_id, got.last_of_line,
                             got.length_error));
            return;
         end
         want = expected_q.pop_front();
         if (got.kind !== want.kind || got.byte_value !== want.byte_value ||
             got.event_id !== want.event_id || got.last_of_line !== want.last_of_line ||
             got.length_error !== want.length_error || fill !== 7'd0)
            report($sformatf({"mismatch: expected kind=%0d value=%02h id=%02h last=%0b err=%0b,",
                              " got kind=%0d value=%02h id=%02h last=%0b err=%0b fill=%02h"},
                             want.kind, want.byte_value, want.event_id, want.last_of_line,
                             want.length_error, got.kind, got.byte_value, got.event_id,
                             got.last_of_line, got.length_error, fill));
      endfunction

      function void check_drained();
         if (expected_q.size() != 0)
            report($sformatf("%0d expected results never arrived", expected_q.size()));
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_tvalid;
   logic        csr_tready;
   logic [7:0]  csr_tdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;
   logic        rsp_tlast;
   logic [1:0]  rsp_tuser;

   deframe_predictor predictor = new();
   int unsigned cycle_count = 0;
   int unsigned bytes_sent = 0;
   int          stall_left = 0;
   bit          source_calm = 1'b1;
   bit          sink_calm = 1'b1;

   length_type_packet_deframer #(.HEADER_BYTES(HEADER_LEN)) dut (
      .clock(clock),
      .reset(reset),
      .csr_tvalid(csr_tvalid),
      .csr_tready(csr_tready),
      .csr_tdata(csr_tdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .rsp_tuser(rsp_tuser)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
         if (!sink_calm && $urandom_range(0, 3) == 0) stall_left = gap_length();
      end
   end

   always @(posedge clock) begin
      result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind = rsp_tuser;
         got.byte_value = rsp_tdata[7:0];
         got.event_id = rsp_tdata[15:8];
         got.length_error = rsp_tdata[16];
         got.last_of_line = rsp_tlast;
         predictor.check_result(got, rsp_tdata[23:17]);
      end
   end

   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = 0;
      if (!source_calm && $urandom_range(0, 99) >= 60) gap = gap_length();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      do @(posedge clock); while (!req_tready);
      predictor.take_byte(b);
      bytes_sent++;
   endtask

   task automatic write_image_code(input logic [7:0] code);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (predictor.expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_tvalid <= 1'b1;
      csr_tdata <= code;
      do @(posedge clock); while (!csr_tready);
      predictor.image_code = code;
      @(negedge clock);
      csr_tvalid <= 1'b0;
   endtask

   task automatic send_packet(input logic [15:0] length, input logic [7:0] ptype,
                              input int fill, input int split_at,
                              input logic [7:0] split_code);
      int         payload;
      logic [7:0] b;
      for (int i = 0; i < HEADER_LEN; i++) begin
         case (i)
            1: b = length[15:8];
            2: b = length[7:0];
            4: b = ptype;
            default: b = 8'($urandom_range(0, 255));
         endcase
         send_byte(b);
      end
      payload = (length > HEADER_LEN) ? int'(length) - HEADER_LEN : 0;
      for (int i = 0; i < payload; i++) begin
         if (i == split_at) write_image_code(split_code);
         b = (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
         send_byte(b);
      end
   endtask

   task automatic send_random_packet();
      int          r;
      int          split;
      logic [15:0] length;
      logic [7:0]  ptype;
      r = $urandom_range(0, 99);
      split = -1;
      ptype = $urandom_range(0, 1) ? predictor.image_code : 8'($urandom_range(0, 255));
      if (r < 15) begin
         length = 16'($urandom_range(0, HEADER_LEN));
         ptype = 8'($urandom_range(0, 255));
      end else if (r < 20) begin
         length = 16'(HEADER_LEN + $urandom_range(100, 300));
      end else begin
         length = 16'(HEADER_LEN + $urandom_range(1, 24));
      end
      if (length > HEADER_LEN + 1 && $urandom_range(0, 19) == 0)
         split = $urandom_range(1, int'(length) - HEADER_LEN - 1);
      send_packet(length, ptype, -1, split,
                  $urandom_range(0, 1) ? ptype : 8'($urandom_range(0, 255)));
   endtask

   initial begin
      reset = 1'b1;
      csr_tvalid = 1'b0;
      csr_tdata = '0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      send_packet(16'd9, 8'h01, 8'hFF, -1, 8'h00);
      send_packet(16'd12, 8'h01, 8'h00, -1, 8'h00);
      send_packet(16'd9, 8'h37, 8'hA5, -1, 8'h00);
      send_packet(16'd20, 8'hFE, -1, -1, 8'h00);
      send_packet(16'd8, 8'h01, -1, -1, 8'h00);
      send_packet(16'd0, 8'h80, -1, -1, 8'h00);
      send_packet(16'd5, 8'h01, -1, -1, 8'h00);
      send_packet(16'h0110, 8'h01, -1, -1, 8'h00);

      write_image_code(8'h00);
      send_packet(16'd10, 8'h00, -1, -1, 8'h00);
      send_packet(16'd0, 8'h00, -1, -1, 8'h00);
      send_packet(16'd10, 8'h01, -1, -1, 8'h00);

      write_image_code(8'hFF);
      send_packet(16'd11, 8'hFF, -1, -1, 8'h00);
      send_packet(16'd14, 8'hFF, -1, 3, 8'h42);
      send_packet(16'd14, 8'h10, -1, 3, 8'h10);

      while (bytes_sent < ITEM_COUNT) begin
         source_calm = ($urandom_range(0, 3) == 0);
         sink_calm = ($urandom_range(0, 3) == 0);
         repeat ($urandom_range(5, 15)) begin
            if (bytes_sent < ITEM_COUNT) send_random_packet();
         end
         case ($urandom_range(0, 3))
            0: write_image_code(8'h00);
            1: write_image_code(8'hFF);
            default: write_image_code(8'($urandom_range(0, 255)));
         endcase
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      sink_calm = 1'b0;
      while (predictor.expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      predictor.check_drained();
      if (predictor.mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
